@@ design/bbf_pkg.sv @@
// Shared types, constants and helpers for the bounded byte stream FIFO.
// Used by bbf_store, bbf_ctrl and the top level; depends on nothing else.
package bbf_pkg;

  // Buffer geometry and run limit
  localparam int BUFFER_DEPTH = 64;
  localparam int MAX_RUN      = 64;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 7;
  localparam int TOTAL_W = 32;

  // Stream payload widths (whole bytes)
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 96;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic [LEVEL_W-1:0] CAPACITY_RESET = LEVEL_W'(64);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  // Request to the byte store
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Advance a ring pointer by amt entries, amt never above the depth
  function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] ptr,
                                                input logic [LEVEL_W-1:0] amt);
    logic [ADDR_W+LEVEL_W-1:0] sum;
    sum = (ADDR_W+LEVEL_W)'(ptr) + (ADDR_W+LEVEL_W)'(amt);
    if (sum >= (ADDR_W+LEVEL_W)'(BUFFER_DEPTH)) begin
      sum = sum - (ADDR_W+LEVEL_W)'(BUFFER_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

@@ design/bounded_byte_stream_fifo.sv @@
// Top level of the bounded byte stream FIFO: stream ports, APB register and
// the instances of bbf_ctrl and bbf_store. Depends on bbf_pkg.
//
// Use: one command per input transaction on s_t*. s_tdata carries command,
// data_byte and length. Write, end-input, pop, unknown commands and
// peek/read that give no bytes (zero length, empty, error set or over-long
// read) return one status-only result on m_t*. A peek or read of n bytes
// returns n results with m_tuser high, m_tlast on the last one.
// Every result also carries the flags, level, free space and the two
// totals as they stand after the command.
// Timing: a status result appears the cycle after acceptance. A run's
// first byte passes the run state, the store's read register and the
// result register, then one byte per cycle follows, paced by the
// registered read port of the byte store.
// A command is accepted only when no run is in progress and the result
// register is empty or being taken; so single-result commands sustain one
// per cycle. A stalled m_tready holds the result register and pauses the run.
// Reset (rst, synchronous) empties the FIFO, clears flags and totals and
// sets capacity_limit to 64; byte storage is not cleared and needs no pass.
// APB: capacity_limit at byte address 0, pready always high.
module bounded_byte_stream_fifo (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bbf_pkg::PADDR_W-1:0]     paddr,
  input  logic [bbf_pkg::PDATA_W-1:0]     pwdata,
  output logic [bbf_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  // Command stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] command, [10:3] data_byte, [17:11] length, [23:18] zero
  input  logic [bbf_pkg::IN_TDATA_W-1:0]  s_tdata,
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] out_byte, [8] write_accepted, [9] error_flag, [10] ended_flag,
  // [11] eof_flag, [18:12] fill_level, [25:19] free_space,
  // [57:26] total_written, [89:58] total_read, [95:90] zero
  output logic [bbf_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  // [0] byte_valid
  output logic                            m_tuser
);
  import bbf_pkg::*;

  logic [LEVEL_W-1:0] capacity_limit;
  logic               cfg_write;
  mem_req_t           mem_req;
  logic [BYTE_W-1:0]  mem_rd_data;

  logic [BYTE_W-1:0]  out_byte;
  logic               write_accepted;
  logic               error_flag;
  logic               ended_flag;
  logic               eof_flag;
  logic [LEVEL_W-1:0] fill_level;
  logic [LEVEL_W-1:0] free_space;
  logic [TOTAL_W-1:0] total_written;
  logic [TOTAL_W-1:0] total_read;

  // Register the capacity limit
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CFG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity_limit <= pwdata[LEVEL_W-1:0];
    end
  end

  // Return the register on reads
  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_CAPACITY) begin
      prdata = PDATA_W'(capacity_limit);
    end
  end

  bbf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .capacity_limit (capacity_limit),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .command        (s_tdata[2:0]),
    .data_byte      (s_tdata[10:3]),
    .length         (s_tdata[17:11]),
    .mem_req        (mem_req),
    .mem_rd_data    (mem_rd_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_byte       (out_byte),
    .byte_valid     (m_tuser),
    .run_last       (m_tlast),
    .write_accepted (write_accepted),
    .error_flag     (error_flag),
    .ended_flag     (ended_flag),
    .eof_flag       (eof_flag),
    .fill_level     (fill_level),
    .free_space     (free_space),
    .total_written  (total_written),
    .total_read     (total_read)
  );

  bbf_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  // Pack the result payload
  assign m_tdata = {6'b0, total_read, total_written, free_space, fill_level,
                    eof_flag, ended_flag, error_flag, write_accepted, out_byte};

endmodule

@@ design/bbf_store.sv @@
// Byte storage of the FIFO: one write port, one registered read port.
// Depends on bbf_pkg for the request struct and the geometry.
module bbf_store (
  input  logic                      clk,
  input  bbf_pkg::mem_req_t         req,
  output logic [bbf_pkg::BYTE_W-1:0] rd_data
);
  import bbf_pkg::*;

  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

  // Store written bytes
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ design/bbf_ctrl.sv @@
// Command sequencer of the FIFO: pointers, level, flags, totals, the byte
// run walker and the result register. Depends on bbf_pkg.
module bbf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bbf_pkg::LEVEL_W-1:0] capacity_limit,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bbf_pkg::CMD_W-1:0]   command,
  input  logic [bbf_pkg::BYTE_W-1:0]  data_byte,
  input  logic [bbf_pkg::LEVEL_W-1:0] length,
  output bbf_pkg::mem_req_t           mem_req,
  input  logic [bbf_pkg::BYTE_W-1:0]  mem_rd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbf_pkg::BYTE_W-1:0]  out_byte,
  output logic                        byte_valid,
  output logic                        run_last,
  output logic                        write_accepted,
  output logic                        error_flag,
  output logic                        ended_flag,
  output logic                        eof_flag,
  output logic [bbf_pkg::LEVEL_W-1:0] fill_level,
  output logic [bbf_pkg::LEVEL_W-1:0] free_space,
  output logic [bbf_pkg::TOTAL_W-1:0] total_written,
  output logic [bbf_pkg::TOTAL_W-1:0] total_read
);
  import bbf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic               state;
  logic [ADDR_W-1:0]  head_pointer;
  logic [ADDR_W-1:0]  tail_pointer;
  logic [LEVEL_W-1:0] held_count;
  logic               input_done;
  logic               error_mark;
  logic [TOTAL_W-1:0] written_total;
  logic [TOTAL_W-1:0] read_total;

  // Run walker
  logic [ADDR_W-1:0]  walk_ptr;
  logic [LEVEL_W-1:0] issue_left;
  logic [LEVEL_W-1:0] deliver_left;
  logic               rd_pending;

  logic [LEVEL_W-1:0] eff_cap;
  logic [LEVEL_W-1:0] len_clamped;
  logic [LEVEL_W-1:0] run_len;
  logic               accept;
  logic               out_free;
  logic               load;
  logic               issue;
  logic               write_ok;
  logic               read_fault;
  logic               start_run;

  // Derive capacity, clamped length and run length
  always_comb begin
    eff_cap     = (capacity_limit > LEVEL_W'(BUFFER_DEPTH)) ? LEVEL_W'(BUFFER_DEPTH)
                                                            : capacity_limit;
    len_clamped = (length > LEVEL_W'(MAX_RUN)) ? LEVEL_W'(MAX_RUN) : length;
    run_len     = (len_clamped < held_count) ? len_clamped : held_count;
    write_ok    = !input_done && !error_mark && (held_count < eff_cap);
    read_fault  = (command == CMD_READ) && (len_clamped > held_count);
    start_run   = ((command == CMD_PEEK) || (command == CMD_READ)) && !read_fault &&
                  !error_mark && (run_len != '0);
  end

  // Handshake and walker control
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign load     = (state == ST_RUN) && rd_pending && out_free;
  assign issue    = (state == ST_RUN) && (issue_left != '0) && (!rd_pending || load);

  // Drive the store
  always_comb begin
    mem_req.wr_en   = accept && (command == CMD_WRITE) && write_ok;
    mem_req.wr_addr = tail_pointer;
    mem_req.wr_data = data_byte;
    mem_req.rd_en   = issue;
    mem_req.rd_addr = walk_ptr;
  end

  // Status straight from the state registers, which hold through a run
  always_comb begin
    error_flag    = error_mark;
    ended_flag    = input_done;
    eof_flag      = input_done && (held_count == '0);
    fill_level    = held_count;
    free_space    = (eff_cap > held_count) ? eff_cap - held_count : '0;
    total_written = written_total;
    total_read    = read_total;
  end

  // Command execution and run sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      head_pointer   <= '0;
      tail_pointer   <= '0;
      held_count     <= '0;
      input_done     <= 1'b0;
      error_mark     <= 1'b0;
      written_total  <= '0;
      read_total     <= '0;
      issue_left     <= '0;
      deliver_left   <= '0;
      rd_pending     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Fill the result register on a status result or a fetched byte,
      // release it once taken
      if (accept) begin
        out_valid <= !start_run;
      end else if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (accept) begin
        // Default: one status-only result
        out_byte       <= '0;
        byte_valid     <= 1'b0;
        run_last       <= 1'b1;
        write_accepted <= (command == CMD_WRITE) && write_ok;
        unique case (command) inside
          CMD_WRITE: begin
            if (write_ok) begin
              tail_pointer   <= ptr_add(tail_pointer, LEVEL_W'(1));
              held_count     <= held_count + LEVEL_W'(1);
              written_total  <= written_total + TOTAL_W'(1);
            end
          end
          CMD_END: begin
            input_done <= 1'b1;
          end
          CMD_PEEK, CMD_READ: begin
            if (read_fault) begin
              error_mark <= 1'b1;
            end else if (start_run) begin
              // Start a run of byte results from the head
              state        <= ST_RUN;
              walk_ptr     <= head_pointer;
              issue_left   <= run_len;
              deliver_left <= run_len;
              if (command == CMD_READ) begin
                head_pointer <= ptr_add(head_pointer, run_len);
                held_count   <= held_count - run_len;
                read_total   <= read_total + TOTAL_W'(run_len);
              end
            end
          end
          CMD_POP: begin
            if (!error_mark && (length != '0)) begin
              if (length > held_count) begin
                error_mark <= 1'b1;
              end else begin
                head_pointer <= ptr_add(head_pointer, length);
                held_count   <= held_count - length;
                read_total   <= read_total + TOTAL_W'(length);
              end
            end
          end
          default: begin
          end
        endcase
      end

      // Issue the next store read
      if (issue) begin
        walk_ptr   <= ptr_add(walk_ptr, LEVEL_W'(1));
        issue_left <= issue_left - LEVEL_W'(1);
      end
      if (issue) begin
        rd_pending <= 1'b1;
      end else if (load) begin
        rd_pending <= 1'b0;
      end

      // Move a fetched byte into the result register
      if (load) begin
        out_byte       <= mem_rd_data;
        byte_valid     <= 1'b1;
        run_last       <= (deliver_left == LEVEL_W'(1));
        write_accepted <= 1'b0;
        deliver_left   <= deliver_left - LEVEL_W'(1);
        if (deliver_left == LEVEL_W'(1)) begin
          state <= ST_IDLE;
        end
      end
    end
  end

endmodule
